/* sv/quadratic_spline_length_and_position_unit_assert.svh */
// Assertion macros for the spline unit controller.
`ifndef QUADRATIC_SPLINE_LENGTH_AND_POSITION_UNIT_ASSERT_SVH
`define QUADRATIC_SPLINE_LENGTH_AND_POSITION_UNIT_ASSERT_SVH

// Same-cycle implication, reset masked.
`define QSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define QSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/qsl_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package qsl_pkg;

  localparam int MAX_SEG  = 256;
  localparam int SEG_AW   = $clog2(MAX_SEG);
  localparam int CNT_W    = $clog2(MAX_SEG + 1);
  localparam int MAX_SAMP = 64;
  localparam int SAMP_W   = 7;
  localparam int FRAC     = 16;
  localparam int PT_W     = FRAC + 1;
  localparam int CRD_W    = 32;
  localparam int LEN_W    = 40;
  localparam int NUM_W    = PT_W + 1 + CRD_W;
  localparam int DVD_W    = LEN_W + FRAC;
  localparam int DVS_W    = LEN_W;
  localparam int RAD_W    = 2 * CRD_W + 2;
  localparam int RT_W     = CRD_W + 1;

  localparam logic [LEN_W-1:0]  LEN_MAX     = '1;
  localparam logic [PT_W-1:0]   T_ONE       = PT_W'(1) << FRAC;
  localparam logic [SAMP_W-1:0] DEF_SAMPLES = SAMP_W'(10);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [1:0] REG_OX = 2'd0;
  localparam logic [1:0] REG_OY = 2'd1;
  localparam logic [1:0] REG_SC = 2'd2;

  localparam logic [1:0] STG_A = 2'd0;
  localparam logic [1:0] STG_B = 2'd1;
  localparam logic [1:0] STG_C = 2'd2;

  typedef struct packed {
    logic              load_in;
    logic              add_init;
    logic              lerp_mul;
    logic              lerp_wr_shift;
    logic              lerp_wr_div;
    logic              div_go;
    logic              div_query;
    logic              sq_x;
    logic              sq_y;
    logic              sqrt_go;
    logic              acc;
    logic              add_fin;
    logic              clear;
    logic              tgt;
    logic              scan_step;
    logic              hit_take;
    logic              local_t;
    logic              local_one;
    logic              qdiv_take;
    logic              load_seg;
    logic              rd_j;
    logic              out_load;
    logic              pos_ok;
    logic              query;
    logic              coord_y;
    logic [1:0]        stage;
    logic [SAMP_W-1:0] i_val;
    logic [1:0]        status;
  } qsl_cmd_t;

  typedef struct packed {
    logic [1:0]        action;
    logic              full;
    logic              empty;
    logic              single;
    logic              div_done;
    logic              sqrt_done;
    logic              hit;
    logic              scan_last;
    logic [SAMP_W-1:0] n;
  } qsl_sts_t;

endpackage

/* sv/qsl_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module qsl_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [qsl_pkg::DVD_W-1:0]    dividend,
  input  logic [qsl_pkg::DVS_W-1:0]    divisor,
  output logic                         done,
  output logic [qsl_pkg::DVD_W-1:0]    quot
);

  localparam int CW = $clog2(qsl_pkg::DVD_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [qsl_pkg::DVD_W-1:0]  q_r, q_nxt;
  logic [qsl_pkg::DVS_W-1:0]  d_r, d_nxt;
  logic [qsl_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [qsl_pkg::DVS_W:0]    rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, q_r[qsl_pkg::DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = qsl_pkg::DVS_W'(rem_sh - {1'b0, d_r});
        q_nxt   = {q_r[qsl_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = qsl_pkg::DVS_W'(rem_sh);
        q_nxt   = {q_r[qsl_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(qsl_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* sv/qsl_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module qsl_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qsl_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [qsl_pkg::RT_W-1:0]    root
);

  localparam int CW  = $clog2(qsl_pkg::RT_W + 1);
  localparam int RMW = qsl_pkg::RT_W + 2;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [qsl_pkg::RAD_W-1:0]  rad_r, rad_nxt;
  logic [qsl_pkg::RT_W-1:0]   root_r, root_nxt;
  logic [RMW-1:0]             rem_r, rem_nxt;
  logic [RMW+1:0]             rem_sh, trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, rad_r[qsl_pkg::RAD_W-1 -: 2]};
    trial    = (RMW+2)'({root_r, 2'b01});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = RMW'(rem_sh - trial);
        root_nxt = {root_r[qsl_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = RMW'(rem_sh);
        root_nxt = {root_r[qsl_pkg::RT_W-2:0], 1'b0};
      end
      rad_nxt = {rad_r[qsl_pkg::RAD_W-3:0], 2'b00};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(qsl_pkg::RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* sv/qsl_datapath.sv */
// Spline datapath: config, segment stores, interpolation, chord and search logic.
module qsl_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [qsl_pkg::CRD_W-1:0]          cfg_wdata,
  input  logic [1:0]                         in_action,
  input  logic signed [qsl_pkg::CRD_W-1:0]   in_vx,
  input  logic signed [qsl_pkg::CRD_W-1:0]   in_vy,
  input  logic [qsl_pkg::PT_W-1:0]           in_t,
  input  qsl_pkg::qsl_cmd_t                  cmd,
  output qsl_pkg::qsl_sts_t                  sts,
  output logic [qsl_pkg::LEN_W-1:0]          o_len,
  output logic signed [qsl_pkg::CRD_W-1:0]   o_px,
  output logic signed [qsl_pkg::CRD_W-1:0]   o_py,
  output logic [qsl_pkg::CNT_W-1:0]          o_cnt,
  output logic [1:0]                         o_status
);

  localparam int CW  = qsl_pkg::CRD_W;
  localparam int AW  = qsl_pkg::SEG_AW;
  localparam int LW  = qsl_pkg::LEN_W;
  localparam int NW  = qsl_pkg::NUM_W;
  localparam int PW  = qsl_pkg::PT_W;
  localparam int SW  = qsl_pkg::SAMP_W;
  localparam int KW  = qsl_pkg::CNT_W;

  // configuration
  logic signed [CW-1:0] ox_r, oy_r;
  logic [SW-1:0]        sc_r;

  // latched request
  logic [1:0]           act_r;
  logic signed [CW-1:0] vx_r, vy_r;
  logic [PW-1:0]        t_r;

  // spline state
  logic [KW-1:0]        cnt_r;
  logic [LW-1:0]        lsum_r;
  logic signed [CW-1:0] lex_r, ley_r, lcx_r, lcy_r;

  // working segment
  logic signed [CW-1:0] sx_r, sy_r, cx_r, cy_r, ex_r, ey_r;
  logic signed [CW-1:0] l1_r, l2_r, bx_r, by_r, prx_r, pry_r;
  logic [SW-1:0]        n_r;
  logic signed [NW-1:0] num_r;
  logic [qsl_pkg::RAD_W-1:0] sq_r;
  logic [LW:0]          csum_r;

  // query search
  logic [AW-1:0]        j_r, k_r;
  logic [LW:0]          before_r;
  logic [LW-1:0]        tgt_r, diff_r, len_r;
  logic [PW-1:0]        local_r;

  // output holding register
  logic [LW-1:0]        o_len_r;
  logic signed [CW-1:0] o_px_r, o_py_r;
  logic [KW-1:0]        o_cnt_r;
  logic [1:0]           o_status_r;

  // segment stores, x in the low half
  logic [2*CW-1:0] mem_s [qsl_pkg::MAX_SEG];
  logic [2*CW-1:0] mem_c [qsl_pkg::MAX_SEG];
  logic [2*CW-1:0] mem_e [qsl_pkg::MAX_SEG];
  logic [LW-1:0]   mem_l [qsl_pkg::MAX_SEG];
  logic [2*CW-1:0] rd_s_r, rd_c_r, rd_e_r;
  logic [LW-1:0]   rd_l_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;

  // combinational helpers
  logic [SW-1:0]          n_eff;
  logic [PW-1:0]          t_clamp;
  logic signed [CW-1:0]   ns_x, ns_y, nc_x, nc_y;
  logic signed [CW:0]     half_x, half_y;
  logic signed [CW+1:0]   refl_x, refl_y;
  logic signed [CW-1:0]   lp, lq, lres;
  logic [PW-1:0]          la, lb, lbma;
  logic signed [NW-1:0]   m1, m2, num_nxt;
  logic signed [NW-1:0]   sh_res;
  logic [NW-1:0]          lmag;
  logic [CW:0]            qv, qneg;
  logic signed [CW:0]     dx, dy;
  logic [CW-1:0]          ax, ay;
  logic [2*CW-1:0]        sqm;
  logic [LW:0]            lsum_add;
  logic [LW-1:0]          seg_len;
  logic [PW+LW-1:0]       tprod;
  logic [LW:0]            tgt_ext;
  logic [qsl_pkg::DVD_W-1:0] div_dvd, div_q;
  logic [qsl_pkg::DVS_W-1:0] div_dvs;
  logic                   div_done;
  logic [qsl_pkg::RT_W-1:0] root;
  logic                   sqrt_done;

  function automatic logic signed [CW-1:0] sat32(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] hi, lo;
    hi = (CW+2)'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - (CW+2)'(1);
    if (v > hi) return CW'(hi);
    else if (v < lo) return CW'(lo);
    else return CW'(v);
  endfunction

  always_comb begin
    if (sc_r == '0) n_eff = SW'(1);
    else if (sc_r > SW'(qsl_pkg::MAX_SAMP)) n_eff = SW'(qsl_pkg::MAX_SAMP);
    else n_eff = sc_r;
    t_clamp = (in_t > qsl_pkg::T_ONE) ? qsl_pkg::T_ONE : in_t;
  end

  // start and control point of a new segment
  always_comb begin
    half_x = ((CW+1)'(ox_r) + (CW+1)'(vx_r)) >>> 1;
    half_y = ((CW+1)'(oy_r) + (CW+1)'(vy_r)) >>> 1;
    refl_x = ((CW+2)'(lex_r) <<< 1) - (CW+2)'(lcx_r);
    refl_y = ((CW+2)'(ley_r) <<< 1) - (CW+2)'(lcy_r);
    if (cnt_r == '0) begin
      ns_x = ox_r;
      ns_y = oy_r;
      nc_x = CW'(half_x);
      nc_y = CW'(half_y);
    end else begin
      ns_x = lex_r;
      ns_y = ley_r;
      nc_x = sat32(refl_x);
      nc_y = sat32(refl_y);
    end
  end

  // interpolation operands
  always_comb begin
    case (cmd.stage)
      qsl_pkg::STG_A: begin
        lp = cmd.coord_y ? sy_r : sx_r;
        lq = cmd.coord_y ? cy_r : cx_r;
      end
      qsl_pkg::STG_B: begin
        lp = cmd.coord_y ? cy_r : cx_r;
        lq = cmd.coord_y ? ey_r : ex_r;
      end
      default: begin
        lp = l1_r;
        lq = l2_r;
      end
    endcase
    la      = cmd.query ? local_r : PW'(cmd.i_val);
    lb      = cmd.query ? qsl_pkg::T_ONE : PW'(n_r);
    lbma    = lb - la;
    m1      = NW'($signed({1'b0, lbma}) * lp);
    m2      = NW'($signed({1'b0, la}) * lq);
    num_nxt = m1 + m2 + NW'(lb >> 1);
    sh_res  = num_r >>> qsl_pkg::FRAC;
    // floor division of a negative numerator works on -num + n - 1
    lmag    = num_r[NW-1] ? NW'(-num_r + NW'(n_r) - NW'(1)) : NW'(num_r);
    qv      = div_q[CW:0];
    qneg    = -qv;
    if (cmd.lerp_wr_shift) lres = CW'(sh_res);
    else lres = num_r[NW-1] ? CW'(qneg) : CW'(qv);
  end

  // chord pieces
  always_comb begin
    dx  = (CW+1)'(bx_r) - (CW+1)'(prx_r);
    dy  = (CW+1)'(by_r) - (CW+1)'(pry_r);
    ax  = dx[CW] ? CW'(-dx) : CW'(dx);
    ay  = dy[CW] ? CW'(-dy) : CW'(dy);
    sqm = (cmd.sq_y ? ay : ax) * (cmd.sq_y ? ay : ax);
  end

  always_comb begin
    seg_len  = csum_r[LW] ? qsl_pkg::LEN_MAX : csum_r[LW-1:0];
    lsum_add = {1'b0, lsum_r} + {1'b0, seg_len};
    tprod    = t_r * lsum_r;
    tgt_ext  = {1'b0, tgt_r};
    div_dvd  = cmd.div_query ? {diff_r, qsl_pkg::FRAC'(0)} : qsl_pkg::DVD_W'(lmag);
    div_dvs  = cmd.div_query ? len_r : qsl_pkg::DVS_W'(n_r);
    rd_addr  = cmd.rd_j ? j_r : k_r;
    wr_addr  = cnt_r[AW-1:0];
  end

  qsl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  qsl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_go),
    .radicand (sq_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // stores: write at the fill position, registered read every cycle
  always_ff @(posedge clk) begin
    if (cmd.add_init) begin
      mem_s[wr_addr] <= {ns_y, ns_x};
      mem_c[wr_addr] <= {nc_y, nc_x};
      mem_e[wr_addr] <= {vy_r, vx_r};
    end
    if (cmd.add_fin) begin
      mem_l[wr_addr] <= seg_len;
    end
    rd_s_r <= mem_s[rd_addr];
    rd_c_r <= mem_c[rd_addr];
    rd_e_r <= mem_e[rd_addr];
    rd_l_r <= mem_l[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r   <= '0;
      oy_r   <= '0;
      sc_r   <= qsl_pkg::DEF_SAMPLES;
      cnt_r  <= '0;
      lsum_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          qsl_pkg::REG_OX: ox_r <= cfg_wdata;
          qsl_pkg::REG_OY: oy_r <= cfg_wdata;
          qsl_pkg::REG_SC: sc_r <= cfg_wdata[SW-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        cnt_r  <= '0;
        lsum_r <= '0;
      end else if (cmd.add_fin) begin
        cnt_r  <= cnt_r + KW'(1);
        lsum_r <= lsum_add[LW] ? qsl_pkg::LEN_MAX : lsum_add[LW-1:0];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      vx_r  <= in_vx;
      vy_r  <= in_vy;
      t_r   <= t_clamp;
    end
    if (cmd.add_init) begin
      sx_r   <= ns_x;
      sy_r   <= ns_y;
      cx_r   <= nc_x;
      cy_r   <= nc_y;
      ex_r   <= vx_r;
      ey_r   <= vy_r;
      prx_r  <= ns_x;
      pry_r  <= ns_y;
      n_r    <= n_eff;
      csum_r <= '0;
    end
    if (cmd.load_seg) begin
      sx_r <= rd_s_r[CW-1:0];
      sy_r <= rd_s_r[2*CW-1:CW];
      cx_r <= rd_c_r[CW-1:0];
      cy_r <= rd_c_r[2*CW-1:CW];
      ex_r <= rd_e_r[CW-1:0];
      ey_r <= rd_e_r[2*CW-1:CW];
    end
    if (cmd.lerp_mul) num_r <= num_nxt;
    if (cmd.lerp_wr_shift || cmd.lerp_wr_div) begin
      case (cmd.stage)
        qsl_pkg::STG_A: l1_r <= lres;
        qsl_pkg::STG_B: l2_r <= lres;
        default: begin
          if (cmd.coord_y) by_r <= lres;
          else bx_r <= lres;
        end
      endcase
    end
    if (cmd.sq_x) sq_r <= qsl_pkg::RAD_W'(sqm);
    if (cmd.sq_y) sq_r <= sq_r + qsl_pkg::RAD_W'(sqm);
    if (cmd.acc) begin
      csum_r <= csum_r + (LW+1)'(root);
      prx_r  <= bx_r;
      pry_r  <= by_r;
    end
    if (cmd.add_fin) begin
      lex_r <= ex_r;
      ley_r <= ey_r;
      lcx_r <= cx_r;
      lcy_r <= cy_r;
    end
    if (cmd.tgt) begin
      tgt_r    <= LW'(tprod >> qsl_pkg::FRAC);
      before_r <= '0;
      j_r      <= '0;
    end
    if (cmd.scan_step) begin
      before_r <= before_r + (LW+1)'(rd_l_r);
      j_r      <= j_r + AW'(1);
    end
    if (cmd.hit_take) begin
      k_r    <= j_r;
      diff_r <= LW'(tgt_ext - before_r);
      len_r  <= rd_l_r;
    end
    if (cmd.local_t) begin
      k_r     <= '0;
      local_r <= t_r;
    end
    if (cmd.local_one) begin
      k_r     <= AW'(cnt_r - KW'(1));
      local_r <= qsl_pkg::T_ONE;
    end
    if (cmd.qdiv_take) local_r <= div_q[PW-1:0];
    if (cmd.out_load) begin
      o_len_r    <= lsum_r;
      o_px_r     <= cmd.pos_ok ? bx_r : '0;
      o_py_r     <= cmd.pos_ok ? by_r : '0;
      o_cnt_r    <= cnt_r;
      o_status_r <= cmd.status;
    end
  end

  always_comb begin
    sts.action    = act_r;
    sts.full      = (cnt_r == KW'(qsl_pkg::MAX_SEG));
    sts.empty     = (cnt_r == '0);
    sts.single    = (cnt_r == KW'(1));
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.hit       = (tgt_ext >= before_r) &&
                    ((tgt_ext - before_r) < (LW+1)'(rd_l_r));
    sts.scan_last = ({1'b0, j_r} == KW'(cnt_r - KW'(1)));
    sts.n         = n_r;
  end

  assign o_len    = o_len_r;
  assign o_px     = o_px_r;
  assign o_py     = o_py_r;
  assign o_cnt    = o_cnt_r;
  assign o_status = o_status_r;

endmodule

/* sv/qsl_ctrl.sv */
// Sequencer for vertex adds, queries and clears; owns the handshakes.
module qsl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  qsl_pkg::qsl_sts_t  sts,
  output qsl_pkg::qsl_cmd_t  cmd
);

`include "quadratic_spline_length_and_position_unit_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_L_MUL, S_L_DIV, S_L_WAIT, S_SQ_X, S_SQ_Y, S_SQRT,
    S_SQRT_WAIT, S_ACC, S_ADD_FIN, S_Q_RD, S_Q_CHK, S_Q_DIV, S_Q_DWAIT,
    S_Q_MEM, S_Q_LOAD, S_RESULT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  stage_r, stage_nxt;
  logic                        coord_r, coord_nxt;
  logic                        query_r, query_nxt;
  logic [qsl_pkg::SAMP_W-1:0]  i_r, i_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        pos_ok_r, pos_ok_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    coord_nxt     = coord_r;
    query_nxt     = query_r;
    i_nxt         = i_r;
    status_nxt    = status_r;
    pos_ok_nxt    = pos_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.stage     = stage_r;
    cmd.coord_y   = coord_r;
    cmd.query     = query_r;
    cmd.i_val     = i_r;
    cmd.status    = status_r;
    cmd.pos_ok    = pos_ok_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          status_nxt  = qsl_pkg::STAT_OK;
          pos_ok_nxt  = 1'b0;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        stage_nxt = qsl_pkg::STG_A;
        coord_nxt = 1'b0;
        case (sts.action)
          qsl_pkg::ACT_ADD: begin
            if (sts.full) begin
              status_nxt = qsl_pkg::STAT_FULL;
              state_nxt  = S_RESULT;
            end else begin
              cmd.add_init = 1'b1;
              query_nxt    = 1'b0;
              i_nxt        = qsl_pkg::SAMP_W'(1);
              state_nxt    = S_L_MUL;
            end
          end
          qsl_pkg::ACT_QUERY: begin
            query_nxt = 1'b1;
            if (sts.empty) begin
              status_nxt = qsl_pkg::STAT_EMPTY;
              state_nxt  = S_RESULT;
            end else if (sts.single) begin
              cmd.local_t = 1'b1;
              state_nxt   = S_Q_MEM;
            end else begin
              cmd.tgt   = 1'b1;
              state_nxt = S_Q_RD;
            end
          end
          qsl_pkg::ACT_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESULT;
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_L_MUL: begin
        cmd.lerp_mul = 1'b1;
        state_nxt    = S_L_DIV;
      end
      S_L_DIV, S_L_WAIT: begin
        if (state_r == S_L_DIV && !query_r) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_L_WAIT;
        end else if (query_r || sts.div_done) begin
          cmd.lerp_wr_shift = query_r;
          cmd.lerp_wr_div   = !query_r;
          if (stage_r != qsl_pkg::STG_C) begin
            stage_nxt = stage_r + 2'd1;
            state_nxt = S_L_MUL;
          end else begin
            stage_nxt = qsl_pkg::STG_A;
            coord_nxt = !coord_r;
            if (!coord_r) begin
              state_nxt = S_L_MUL;
            end else if (query_r) begin
              pos_ok_nxt = 1'b1;
              state_nxt  = S_RESULT;
            end else begin
              state_nxt = S_SQ_X;
            end
          end
        end
      end
      S_SQ_X: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sts.sqrt_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (i_r == sts.n) begin
          state_nxt = S_ADD_FIN;
        end else begin
          i_nxt     = i_r + qsl_pkg::SAMP_W'(1);
          state_nxt = S_L_MUL;
        end
      end
      S_ADD_FIN: begin
        cmd.add_fin = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_Q_RD: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        cmd.rd_j = 1'b1;
        if (sts.hit) begin
          cmd.hit_take = 1'b1;
          state_nxt    = S_Q_DIV;
        end else if (sts.scan_last) begin
          // nothing holds the target: last segment at one
          cmd.local_one = 1'b1;
          state_nxt     = S_Q_MEM;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_Q_RD;
        end
      end
      S_Q_DIV: begin
        cmd.div_go    = 1'b1;
        cmd.div_query = 1'b1;
        state_nxt     = S_Q_DWAIT;
      end
      S_Q_DWAIT: begin
        if (sts.div_done) begin
          cmd.qdiv_take = 1'b1;
          state_nxt     = S_Q_MEM;
        end
      end
      S_Q_MEM: state_nxt = S_Q_LOAD;
      S_Q_LOAD: begin
        cmd.load_seg = 1'b1;
        state_nxt    = S_L_MUL;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= qsl_pkg::STG_A;
      coord_r     <= 1'b0;
      query_r     <= 1'b0;
      i_r         <= '0;
      status_r    <= qsl_pkg::STAT_OK;
      pos_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      coord_r     <= coord_nxt;
      query_r     <= query_nxt;
      i_r         <= i_nxt;
      status_r    <= status_nxt;
      pos_ok_r    <= pos_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `QSL_ASSERT_IMP(a_query_no_div, state_r == S_L_WAIT, !query_r,
    "query interpolation waiting on divider")
  `QSL_ASSERT_NXT(a_full_drop, state_r == S_DISP && sts.action == qsl_pkg::ACT_ADD && sts.full,
    state_r == S_RESULT && status_r == qsl_pkg::STAT_FULL, "full store add not dropped")
  `QSL_ASSERT_IMP(a_out_from_result, $rose(out_valid_r), $past(state_r) == S_RESULT,
    "result raised outside result state")
  `QSL_ASSERT_IMP(a_sample_range, state_r == S_ACC, i_r != '0 && i_r <= sts.n,
    "chord index out of range")

endmodule

/* sv/quadratic_spline_length_and_position_unit.sv */
// Top level of the quadratic spline length and position unit.
// Usage:
//   in_*  : one request per handshake; action selects add vertex, query
//           position at param_t, or clear. Every request gives one result.
//   out_* : running total length, queried position (zero unless a query
//           succeeds), segment count and status.
//   cfg_* : origin and sample count; write only while no request is active.
// Sequence: one request at a time. Add vertex costs n chords, each 6
//   interpolations through the shared 56-step divider plus a bit-serial
//   square root and accumulate, n up to 64. A query scans stored lengths
//   segment by segment, then, when a segment holds the target, one divide,
//   and then 6 shift-based interpolations. Clear, a dropped vertex, an
//   empty query and unused codes go straight to the result.
// Reset clears the segment count, total length and origin and sets the
//   sample count to 10; the segment stores need no clearing pass.
// A finished result waits in the output register while out_tready is low;
//   the next request is taken once the block returns to idle, and the
//   following result waits until the held one is taken.
module quadratic_spline_length_and_position_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], vertex_x[33:2], vertex_y[65:34], param_t[82:66], zero pad
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // total_length[39:0], pos_x[71:40], pos_y[103:72], segment_count[112:104],
  // status[114:113], zero pad
  output logic [119:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  qsl_pkg::qsl_cmd_t                 cmd;
  qsl_pkg::qsl_sts_t                 sts;
  logic [qsl_pkg::LEN_W-1:0]         o_len;
  logic signed [qsl_pkg::CRD_W-1:0]  o_px, o_py;
  logic [qsl_pkg::CNT_W-1:0]         o_cnt;
  logic [1:0]                        o_status;

  qsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  qsl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_action (in_tdata[1:0]),
    .in_vx     (in_tdata[33:2]),
    .in_vy     (in_tdata[65:34]),
    .in_t      (in_tdata[82:66]),
    .cmd       (cmd),
    .sts       (sts),
    .o_len     (o_len),
    .o_px      (o_px),
    .o_py      (o_py),
    .o_cnt     (o_cnt),
    .o_status  (o_status)
  );

  assign out_tdata = {5'b0, o_status, o_cnt, o_py, o_px, o_len};

endmodule
